// ===== hdl/lspfe_pkg.sv =====
package lspfe_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_LEDS_DEFAULT      = 8;
    localparam int TICK_INTERVAL_DEFAULT = 10;

    // Field widths
    localparam int LED_W   = 3;
    localparam int CHAN_W  = 8;
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 16;
    localparam int PULSE_W = 40;

    // Command codes
    localparam logic [1:0] CMD_WRITE_COLOUR = 2'd0;
    localparam logic [1:0] CMD_SET_LEVEL    = 2'd1;
    localparam logic [1:0] CMD_TICK         = 2'd2;

    // Pulse patterns, one 5-bit symbol per data bit
    localparam logic [4:0] PULSE_ONE  = 5'h1C;
    localparam logic [4:0] PULSE_ZERO = 5'h10;

    localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'h7F;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hFF;

    // Corrected level: L * (L + KNEE) / (5 * 2^CORR_SHIFT), L in 8.8
    localparam int KNEE        = 64 * 256;
    localparam int CORR_SHIFT  = 22;
    localparam int RECIP_FIVE  = 13108;   // 2^16 / 5, rounded up
    localparam int RECIP_SHIFT = 16;

    // Queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [LED_W-1:0]   led_index;
        logic [CHAN_W-1:0]  red_value;
        logic [CHAN_W-1:0]  green_value;
        logic [CHAN_W-1:0]  blue_value;
        logic [CHAN_W-1:0]  target_level;
        logic [TIME_W-1:0]  ramp_time;
    } cmd_req_t;

    typedef struct packed {
        logic [LED_W-1:0]   out_led;
        logic [PULSE_W-1:0] green_pulses;
        logic [PULSE_W-1:0] red_pulses;
        logic [PULSE_W-1:0] blue_pulses;
        logic               frame_end;
    } result_t;

    // One LED of a frame, handed from the front to the back
    typedef struct packed {
        logic [LED_W-1:0]  led;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] level;
        logic              last;
    } entry_t;

    function automatic logic [PULSE_W-1:0] encode_pulses(input logic [CHAN_W-1:0] v);
        logic [PULSE_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < CHAN_W; b++)
        begin
            acc[b*5 +: 5] = v[b] ? PULSE_ONE : PULSE_ZERO;
        end
        return acc;
    endfunction

endpackage

// ===== hdl/lspfe_fifo.sv =====
module lspfe_fifo #(
    parameter int WIDTH = $bits(lspfe_pkg::entry_t),
    parameter int DEPTH = lspfe_pkg::MID_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lspfe_div.sv =====
module lspfe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] rem_reg;
    logic [15:0] quo_reg;
    logic [16:0] div_reg;
    logic [16:0] trial;
    logic        fits;

    // One quotient bit per cycle, restoring
    assign trial    = {rem_reg[15:0], quo_reg[15]};
    assign fits     = (trial >= div_reg);
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - div_reg) : trial;
            quo_reg <= {quo_reg[14:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 5'd15)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/lspfe_front.sv =====
module lspfe_front #(
    parameter int NUM_LEDS      = lspfe_pkg::NUM_LEDS_DEFAULT,
    parameter int TICK_INTERVAL = lspfe_pkg::TICK_INTERVAL_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lspfe_pkg::cmd_req_t cmd_req,
    output logic                full,
    output logic                mid_push,
    output lspfe_pkg::entry_t   mid_entry,
    input  logic                mid_full
);

    localparam int FRAME_LEN = (NUM_LEDS < 8) ? NUM_LEDS : 8;
    localparam int IDX_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

    // Exact time / TICK_INTERVAL for a 16-bit time through a reciprocal
    localparam int STEP_SHIFT = 16 + $clog2(TICK_INTERVAL);
    localparam longint unsigned STEP_RECIP =
        ((64'd1 << STEP_SHIFT) + 64'(TICK_INTERVAL) - 64'd1) / 64'(TICK_INTERVAL);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEPS,
        S_GAP,
        S_CHECK,
        S_CORR,
        S_CORR_SCALE,
        S_EMIT
    } state_t;

    state_t      state_reg;
    logic [23:0] store_reg [FRAME_LEN];
    logic [15:0] level_reg;
    logic [7:0]  goal_reg;
    logic [15:0] time_reg;
    logic        pending_reg;
    logic [7:0]  before_reg;
    logic        emit_reg;
    logic        neg_reg;
    logic [32:0] prod_reg;
    logic [7:0]  lc_reg;
    logic [2:0]  led_cnt_reg;

    logic        accept;
    logic        ramp_needed;
    logic        has_steps;
    logic [32:0] steps_prod;
    logic [15:0] steps;
    logic        div_start;
    logic [15:0] div_dividend;
    logic [16:0] div_divisor;
    logic        div_busy;
    logic [15:0] div_quotient;
    logic [16:0] gap;
    logic [16:0] gap_mag;
    logic [15:0] delta;
    logic [24:0] scaled;
    logic [8:0]  c_raw;
    logic [7:0]  c_sat;
    logic [7:0]  lc_next;
    logic [23:0] colour;
    logic        last_led;

    assign accept      = push && (state_reg == S_IDLE);
    assign full        = (state_reg != S_IDLE);
    assign ramp_needed = (level_reg[15:8] != goal_reg);
    assign has_steps   = (time_reg >= 16'(TICK_INTERVAL));

    assign steps_prod = {17'd0, time_reg} * 33'(STEP_RECIP);
    assign steps      = 16'(steps_prod >> STEP_SHIFT);

    // Signed gap to the target, divided as a magnitude and truncated toward zero
    assign gap     = {1'b0, goal_reg, 8'h00} - {1'b0, level_reg};
    assign gap_mag = gap[16] ? (17'd0 - gap) : gap;
    assign delta   = neg_reg ? (16'd0 - div_quotient) : div_quotient;

    assign div_start    = (state_reg == S_STEPS);
    assign div_dividend = gap_mag[15:0];
    assign div_divisor  = {1'b0, steps} + 17'd1;

    lspfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Divide by five through a reciprocal, then saturate and lift
    assign scaled = 25'(prod_reg[32:lspfe_pkg::CORR_SHIFT]) * 25'(lspfe_pkg::RECIP_FIVE);
    assign c_raw  = scaled[24:lspfe_pkg::RECIP_SHIFT];
    assign c_sat  = c_raw[8] ? lspfe_pkg::CHAN_MAX : c_raw[7:0];
    assign lc_next = ((level_reg[15:8] != 8'd0) && (c_sat != lspfe_pkg::CHAN_MAX))
                   ? (c_sat + 8'd1) : c_sat;

    assign colour   = store_reg[led_cnt_reg[IDX_W-1:0]];
    assign last_led = (led_cnt_reg == 3'(FRAME_LEN - 1));

    assign mid_push        = (state_reg == S_EMIT) && !mid_full;
    assign mid_entry.led   = led_cnt_reg;
    assign mid_entry.red   = colour[23:16];
    assign mid_entry.green = colour[15:8];
    assign mid_entry.blue  = colour[7:0];
    assign mid_entry.level = lc_reg;
    assign mid_entry.last  = last_led;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                store_reg[i] <= {3{lspfe_pkg::WHITE_LEVEL}};
            end
            level_reg   <= '0;
            goal_reg    <= '0;
            time_reg    <= '0;
            pending_reg <= 1'b0;
            before_reg  <= '0;
            emit_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            prod_reg    <= '0;
            lc_reg      <= '0;
            led_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_req.cmd)
                            lspfe_pkg::CMD_WRITE_COLOUR:
                            begin
                                if ({1'b0, cmd_req.led_index} < 4'(FRAME_LEN))
                                begin
                                    store_reg[cmd_req.led_index[IDX_W-1:0]] <=
                                        {cmd_req.red_value, cmd_req.green_value,
                                         cmd_req.blue_value};
                                end
                                pending_reg <= 1'b1;
                            end
                            lspfe_pkg::CMD_SET_LEVEL:
                            begin
                                goal_reg <= cmd_req.target_level;
                                time_reg <= cmd_req.ramp_time;
                            end
                            lspfe_pkg::CMD_TICK:
                            begin
                                before_reg <= level_reg[15:8];
                                emit_reg   <= pending_reg;
                                if (ramp_needed && has_steps)
                                begin
                                    state_reg <= S_STEPS;
                                end
                                else
                                begin
                                    if (ramp_needed)
                                    begin
                                        level_reg <= {goal_reg, 8'h00};
                                        time_reg  <= '0;
                                    end
                                    state_reg <= S_CHECK;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_STEPS:
                begin
                    neg_reg   <= gap[16];
                    state_reg <= S_GAP;
                end
                S_GAP:
                begin
                    if (!div_busy)
                    begin
                        level_reg <= level_reg + delta;
                        time_reg  <= time_reg - 16'(TICK_INTERVAL);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (emit_reg || (level_reg[15:8] != before_reg))
                    begin
                        pending_reg <= 1'b0;
                        state_reg   <= S_CORR;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CORR:
                begin
                    prod_reg  <= {17'd0, level_reg}
                               * ({17'd0, level_reg} + 33'(lspfe_pkg::KNEE));
                    state_reg <= S_CORR_SCALE;
                end
                S_CORR_SCALE:
                begin
                    lc_reg      <= lc_next;
                    led_cnt_reg <= '0;
                    state_reg   <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!mid_full)
                    begin
                        if (last_led)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            led_cnt_reg <= led_cnt_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/lspfe_back.sv =====
module lspfe_back #(
    parameter int OUT_DEPTH = lspfe_pkg::OUT_DEPTH,
    parameter int CNT_W     = $clog2(OUT_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_empty,
    input  lspfe_pkg::entry_t  mid_entry,
    output logic               mid_pop,
    input  logic [CNT_W-1:0]   out_count,
    output logic               out_push,
    output lspfe_pkg::result_t out_item
);

    logic        s1_valid_reg;
    logic [2:0]  s1_led_reg;
    logic        s1_last_reg;
    logic [15:0] s1_red_reg;
    logic [15:0] s1_green_reg;
    logic [15:0] s1_blue_reg;
    logic [16:0] red_q;
    logic [16:0] green_q;
    logic [16:0] blue_q;

    // Take an entry only when the output queue has room for it and the one in flight
    assign mid_pop = !mid_empty
                  && (({1'b0, out_count} + (CNT_W + 1)'(s1_valid_reg)) < (CNT_W + 1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_led_reg   <= '0;
            s1_last_reg  <= 1'b0;
            s1_red_reg   <= '0;
            s1_green_reg <= '0;
            s1_blue_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= mid_pop;
            if (mid_pop)
            begin
                s1_led_reg   <= mid_entry.led;
                s1_last_reg  <= mid_entry.last;
                s1_red_reg   <= 16'(mid_entry.red) * 16'(mid_entry.level);
                s1_green_reg <= 16'(mid_entry.green) * 16'(mid_entry.level);
                s1_blue_reg  <= 16'(mid_entry.blue) * 16'(mid_entry.level);
            end
        end
    end

    // Exact x / 255 for 16-bit x up to 65534
    assign red_q   = {1'b0, s1_red_reg} + 17'(s1_red_reg[15:8]) + 17'd1;
    assign green_q = {1'b0, s1_green_reg} + 17'(s1_green_reg[15:8]) + 17'd1;
    assign blue_q  = {1'b0, s1_blue_reg} + 17'(s1_blue_reg[15:8]) + 17'd1;

    assign out_push              = s1_valid_reg;
    assign out_item.out_led      = s1_led_reg;
    assign out_item.green_pulses = lspfe_pkg::encode_pulses(green_q[15:8]);
    assign out_item.red_pulses   = lspfe_pkg::encode_pulses(red_q[15:8]);
    assign out_item.blue_pulses  = lspfe_pkg::encode_pulses(blue_q[15:8]);
    assign out_item.frame_end    = s1_last_reg;

endmodule

// ===== hdl/led_strip_pulse_frame_encoder.sv =====
// LED strip pulse frame encoder. Requests come in through a queue-style port
// (push/full) and carry one of three commands: write one LED colour, set the
// brightness target and ramp time, or tick. Colour writes and level settings
// give no results and leave full low; a colour write marks a frame as due.
// A tick moves the 8.8 brightness level one ramp step and, when the whole
// level changed or a frame is due, emits one frame: one result per LED for
// min(NUM_LEDS, 8) LEDs, each channel scaled by the corrected level and
// turned into 40 bits of pulse symbols in green, red, blue order, with
// frame_end on the last entry. Results leave through a queue-style port
// (empty/pop). Colours reset to 0x7F white, level and target to zero.
// Path: a tick without a ramp step passes the check state and, if a frame
// is due, the correction and scale states before the front pushes the first
// entry into the middle queue; the back registers each entry on its way to
// the result queue. A ramp step takes the steps left from a reciprocal
// multiply and gap / (steps + 1) from a bit-serial divider. The front then
// hands out one LED entry per cycle while the middle queue has room; the
// back scales and encodes one entry per cycle into a 4-deep result queue,
// so the frame streams at one LED per cycle while results are popped. full
// stays high from the tick until its last entry has left the front.
module led_strip_pulse_frame_encoder #(
    parameter int NUM_LEDS      = lspfe_pkg::NUM_LEDS_DEFAULT,
    parameter int TICK_INTERVAL = lspfe_pkg::TICK_INTERVAL_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lspfe_pkg::cmd_req_t command,
    output logic                full,
    input  logic                pop,
    output lspfe_pkg::result_t  result,
    output logic                empty
);

    localparam int ENTRY_W   = $bits(lspfe_pkg::entry_t);
    localparam int RESULT_W  = $bits(lspfe_pkg::result_t);
    localparam int MID_CNT_W = $clog2(lspfe_pkg::MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(lspfe_pkg::OUT_DEPTH + 1);

    // Front to middle queue
    logic                   mid_push;
    lspfe_pkg::entry_t      front_entry;
    logic                   mid_full;
    logic                   mid_pop;
    logic [ENTRY_W-1:0]     mid_rdata;
    lspfe_pkg::entry_t      mid_entry;
    logic                   mid_empty;
    logic [MID_CNT_W-1:0]   mid_count;

    // Back to result queue
    logic                   out_push;
    lspfe_pkg::result_t     back_item;
    logic                   out_full;
    logic [RESULT_W-1:0]    out_rdata;
    logic [OUT_CNT_W-1:0]   out_count;

    // Decode commands, run the ramp, hand out one LED entry per cycle while the middle queue has room
    lspfe_front #(
        .NUM_LEDS      (NUM_LEDS),
        .TICK_INTERVAL (TICK_INTERVAL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_req   (command),
        .full      (full),
        .mid_push  (mid_push),
        .mid_entry (front_entry),
        .mid_full  (mid_full)
    );

    // Hold entries between the two sides so each can stall on its own
    lspfe_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (lspfe_pkg::MID_DEPTH),
        .CNT_W (MID_CNT_W)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (front_entry),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign mid_entry = mid_rdata;

    // Scale each channel and encode pulses
    lspfe_back #(
        .OUT_DEPTH (lspfe_pkg::OUT_DEPTH),
        .CNT_W     (OUT_CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_entry (mid_entry),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (back_item)
    );

    // Result queue; the back never pushes into it when it is full
    lspfe_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (lspfe_pkg::OUT_DEPTH),
        .CNT_W (OUT_CNT_W)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    // Drop the middle count and the result full flag: the middle flags and result credit cover both
    logic unused_status;
    assign unused_status = out_full ^ (^mid_count);

    assign result = out_rdata;

endmodule
